[hw/rtl/i2cram_pkg.sv]
package i2cram_pkg;

    localparam int unsigned BUS_COUNT = 8;

    localparam logic [16:0] STRETCH_LIMIT_RESET = 17'd100000;
    localparam logic [7:0]  UNIT_TICKS_RESET    = 8'd1;

    // configuration register indexes
    localparam logic CFG_UNIT_TICKS    = 1'b0;
    localparam logic CFG_STRETCH_LIMIT = 1'b1;

    // sequencer phases
    localparam logic [4:0] PH_IDLE        = 5'd0;
    localparam logic [4:0] PH_ST_A        = 5'd1;
    localparam logic [4:0] PH_ST_B        = 5'd2;
    localparam logic [4:0] PH_TX_SETUP    = 5'd3;
    localparam logic [4:0] PH_TX_HIGH     = 5'd4;
    localparam logic [4:0] PH_TX_HOLD     = 5'd5;
    localparam logic [4:0] PH_ACK_LOW     = 5'd6;
    localparam logic [4:0] PH_ACK_STRETCH = 5'd7;
    localparam logic [4:0] PH_ACK_GIVEUP  = 5'd8;
    localparam logic [4:0] PH_ACK_HIGH    = 5'd9;
    localparam logic [4:0] PH_ACK_TAIL    = 5'd10;
    localparam logic [4:0] PH_RX_LOW      = 5'd11;
    localparam logic [4:0] PH_RX_HIGH1    = 5'd12;
    localparam logic [4:0] PH_RX_HIGH2    = 5'd13;
    localparam logic [4:0] PH_RX_TAIL     = 5'd14;
    localparam logic [4:0] PH_NK_LOW      = 5'd15;
    localparam logic [4:0] PH_NK_HIGH     = 5'd16;
    localparam logic [4:0] PH_NK_TAIL     = 5'd17;
    localparam logic [4:0] PH_SP_LOW      = 5'd18;
    localparam logic [4:0] PH_SP_HIGH     = 5'd19;

    // byte segment kinds
    localparam logic [2:0] SEG_START = 3'd0;
    localparam logic [2:0] SEG_AW    = 3'd1;
    localparam logic [2:0] SEG_HI    = 3'd2;
    localparam logic [2:0] SEG_LO    = 3'd3;
    localparam logic [2:0] SEG_DATA  = 3'd4;
    localparam logic [2:0] SEG_AR    = 3'd5;
    localparam logic [2:0] SEG_RECV  = 3'd6;
    localparam logic [2:0] SEG_STOP  = 3'd7;

    localparam logic [3:0] UNITS_1  = 4'd1;
    localparam logic [3:0] UNITS_2  = 4'd2;
    localparam logic [3:0] UNITS_4  = 4'd4;
    localparam logic [3:0] UNITS_10 = 4'd10;

    typedef struct packed {
        logic        is_read;
        logic        wide;
        logic [6:0]  dev;
        logic [15:0] regaddr;
        logic [7:0]  wbyte;
        logic [2:0]  bus;
    } cmd_t;

    typedef struct packed {
        logic [4:0]  phase;
        logic [2:0]  byte_step;
        logic [2:0]  bit_count;
        logic [7:0]  shift_byte;
        logic [11:0] delay_count;
        logic [16:0] stretch_count;
        logic        clk_low;
        logic        dat_low;
    } seq_t;

    // segment order per transaction shape: row is {is_read, wide}
    function automatic logic [2:0] seg_kind(logic [1:0] row, logic [2:0] step);
        logic [2:0] k;
        k = SEG_STOP;
        case (row)
            2'd0:
            begin
                case (step)
                    3'd0:    k = SEG_START;
                    3'd1:    k = SEG_AW;
                    3'd2:    k = SEG_LO;
                    3'd3:    k = SEG_DATA;
                    default: k = SEG_STOP;
                endcase
            end
            2'd1:
            begin
                case (step)
                    3'd0:    k = SEG_START;
                    3'd1:    k = SEG_AW;
                    3'd2:    k = SEG_HI;
                    3'd3:    k = SEG_LO;
                    3'd4:    k = SEG_DATA;
                    default: k = SEG_STOP;
                endcase
            end
            2'd2:
            begin
                case (step)
                    3'd0:    k = SEG_START;
                    3'd1:    k = SEG_AW;
                    3'd2:    k = SEG_LO;
                    3'd3:    k = SEG_START;
                    3'd4:    k = SEG_AR;
                    3'd5:    k = SEG_RECV;
                    default: k = SEG_STOP;
                endcase
            end
            default:
            begin
                case (step)
                    3'd0:    k = SEG_START;
                    3'd1:    k = SEG_AW;
                    3'd2:    k = SEG_HI;
                    3'd3:    k = SEG_LO;
                    3'd4:    k = SEG_START;
                    3'd5:    k = SEG_AR;
                    3'd6:    k = SEG_RECV;
                    default: k = SEG_STOP;
                endcase
            end
        endcase
        return k;
    endfunction

    function automatic logic [11:0] wait_len(logic [3:0] units, logic [7:0] u);
        logic [11:0] p;
        p = {8'd0, units} * {4'd0, u};
        return p;
    endfunction

    function automatic seq_t put_bit(seq_t s, logic [7:0] u);
        seq_t r;
        r = s;
        r.dat_low     = ~s.shift_byte[3'd7 - s.bit_count];
        r.delay_count = wait_len(UNITS_2, u);
        r.phase       = PH_TX_SETUP;
        return r;
    endfunction

    function automatic seq_t enter_seg(seq_t s, cmd_t c, logic [7:0] u);
        seq_t r;
        logic [2:0] kind;
        r = s;
        kind = seg_kind({c.is_read, c.wide}, s.byte_step);
        case (kind)
            SEG_START:
            begin
                r.clk_low     = 1'b0;
                r.dat_low     = 1'b0;
                r.delay_count = wait_len(UNITS_4, u);
                r.phase       = PH_ST_A;
            end
            SEG_RECV:
            begin
                r.clk_low     = 1'b1;
                r.dat_low     = 1'b0;
                r.shift_byte  = 8'd0;
                r.bit_count   = 3'd0;
                r.delay_count = wait_len(UNITS_4, u);
                r.phase       = PH_RX_LOW;
            end
            SEG_STOP:
            begin
                r.clk_low     = 1'b1;
                r.dat_low     = 1'b1;
                r.delay_count = wait_len(UNITS_4, u);
                r.phase       = PH_SP_LOW;
            end
            default:
            begin
                case (kind)
                    SEG_AW:  r.shift_byte = {c.dev, 1'b0};
                    SEG_AR:  r.shift_byte = {c.dev, 1'b1};
                    SEG_HI:  r.shift_byte = c.regaddr[15:8];
                    SEG_LO:  r.shift_byte = c.regaddr[7:0];
                    default: r.shift_byte = c.wbyte;
                endcase
                r.clk_low   = 1'b1;
                r.bit_count = 3'd0;
                r = put_bit(r, u);
            end
        endcase
        return r;
    endfunction

endpackage

[hw/rtl/i2c_register_access_master_unit.sv]
// a word's result is registered at the edge that accepts it and shows on the outputs in the next cycle
// throughput: one word per cycle while in_stall is low; the bit sequencer takes a single step per tick word
// in_stall is high only while a result waits and out_stall holds it
// reset (rst_n low, asynchronous): sequencer idle, pins released, unit_ticks 1,
// stretch_limit 100000, latched command and received byte cleared
module i2c_register_access_master_unit
(
    input  logic        clk,
    input  logic        rst_n,

    // configuration write port
    input  logic        cfg_write_en,
    input  logic        cfg_index,
    input  logic [16:0] cfg_data,

    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic        is_read,
    input  logic        wide_register_address,
    input  logic [6:0]  device_address,
    input  logic [15:0] register_address,
    input  logic [7:0]  write_byte,
    input  logic [2:0]  bus_number,
    input  logic        clock_pin_level,
    input  logic        data_pin_level,

    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic        busy_res,
    output logic        done_res,
    output logic        failed,
    output logic [7:0]  read_byte,
    output logic [2:0]  active_bus,
    output logic        clock_drive_low,
    output logic        data_drive_low
);

    // configuration registers
    logic [7:0]  unit_ticks_reg;
    logic [16:0] stretch_limit_reg;

    // sequencer state
    i2cram_pkg::seq_t seq_reg, seq_next;
    i2cram_pkg::cmd_t cmd_reg, cmd_next;
    logic             nack_reg, nack_next;
    logic [7:0]       rx_reg, rx_next;

    // result register
    logic             out_valid_reg;
    logic             busy_reg, done_reg, failed_reg;
    logic [7:0]       read_byte_reg;
    logic [2:0]       active_bus_reg;
    logic             clk_low_reg, dat_low_reg;

    logic             in_accept;
    logic             out_take;
    logic [7:0]       unit;
    logic             done_c, fail_c;
    i2cram_pkg::cmd_t cmd_in;

    // a zero unit count behaves as one
    assign unit = (unit_ticks_reg == 8'd0) ? 8'd1 : unit_ticks_reg;

    // one-deep output register: a new word enters whenever the slot is free or emptying
    assign in_stall  = out_valid_reg & out_stall;
    assign in_accept = in_valid & ~in_stall;
    assign out_take  = out_valid_reg & ~out_stall;

    assign cmd_in = '{is_read: is_read, wide: wide_register_address, dev: device_address,
                      regaddr: register_address, wbyte: write_byte, bus: bus_number};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_ticks_reg    <= i2cram_pkg::UNIT_TICKS_RESET;
            stretch_limit_reg <= i2cram_pkg::STRETCH_LIMIT_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                i2cram_pkg::CFG_UNIT_TICKS:    unit_ticks_reg    <= cfg_data[7:0];
                i2cram_pkg::CFG_STRETCH_LIMIT: stretch_limit_reg <= cfg_data;
                default:                       unit_ticks_reg    <= unit_ticks_reg;
            endcase
        end
    end

    // one sequencer step per accepted word
    always_comb
    begin
        seq_next  = seq_reg;
        cmd_next  = cmd_reg;
        nack_next = nack_reg;
        rx_next   = rx_reg;
        done_c    = 1'b0;
        fail_c    = 1'b0;
        if (!action)
        begin
            // command: taken only while idle
            if (seq_reg.phase == i2cram_pkg::PH_IDLE)
            begin
                cmd_next  = cmd_in;
                nack_next = 1'b0;
                if ({1'b0, bus_number} >= 4'(i2cram_pkg::BUS_COUNT))
                begin
                    done_c = 1'b1;
                    fail_c = 1'b1;
                end
                else
                begin
                    seq_next.byte_step = 3'd0;
                    seq_next = i2cram_pkg::enter_seg(seq_next, cmd_in, unit);
                end
            end
        end
        else if (seq_reg.phase != i2cram_pkg::PH_IDLE)
        begin
            if (seq_reg.delay_count > 12'd1)
            begin
                seq_next.delay_count = seq_reg.delay_count - 12'd1;
            end
            else
            begin
                // end of the current wait
                case (seq_reg.phase)
                    i2cram_pkg::PH_ST_A:
                    begin
                        seq_next.dat_low     = 1'b1;
                        seq_next.delay_count = i2cram_pkg::wait_len(i2cram_pkg::UNITS_4, unit);
                        seq_next.phase       = i2cram_pkg::PH_ST_B;
                    end
                    i2cram_pkg::PH_ST_B:
                    begin
                        seq_next.clk_low   = 1'b1;
                        seq_next.byte_step = seq_reg.byte_step + 3'd1;
                        seq_next = i2cram_pkg::enter_seg(seq_next, cmd_reg, unit);
                    end
                    i2cram_pkg::PH_TX_SETUP:
                    begin
                        seq_next.clk_low     = 1'b0;
                        seq_next.delay_count = i2cram_pkg::wait_len(i2cram_pkg::UNITS_4, unit);
                        seq_next.phase       = i2cram_pkg::PH_TX_HIGH;
                    end
                    i2cram_pkg::PH_TX_HIGH:
                    begin
                        seq_next.clk_low     = 1'b1;
                        seq_next.delay_count = i2cram_pkg::wait_len(i2cram_pkg::UNITS_2, unit);
                        seq_next.phase       = i2cram_pkg::PH_TX_HOLD;
                    end
                    i2cram_pkg::PH_TX_HOLD:
                    begin
                        if (seq_reg.bit_count == 3'd7)
                        begin
                            // release sda for the ack slot
                            seq_next.dat_low     = 1'b0;
                            seq_next.clk_low     = 1'b1;
                            seq_next.delay_count =
                                i2cram_pkg::wait_len(i2cram_pkg::UNITS_10, unit);
                            seq_next.phase       = i2cram_pkg::PH_ACK_LOW;
                        end
                        else
                        begin
                            seq_next.bit_count = seq_reg.bit_count + 3'd1;
                            seq_next = i2cram_pkg::put_bit(seq_next, unit);
                        end
                    end
                    i2cram_pkg::PH_ACK_LOW:
                    begin
                        // release scl, look for stretching on the next tick
                        seq_next.clk_low       = 1'b0;
                        seq_next.stretch_count = 17'd0;
                        seq_next.delay_count   = 12'd1;
                        seq_next.phase         = i2cram_pkg::PH_ACK_STRETCH;
                    end
                    i2cram_pkg::PH_ACK_STRETCH:
                    begin
                        if (clock_pin_level)
                        begin
                            seq_next.delay_count =
                                i2cram_pkg::wait_len(i2cram_pkg::UNITS_10, unit);
                            seq_next.phase       = i2cram_pkg::PH_ACK_HIGH;
                        end
                        else if (seq_reg.stretch_count >= stretch_limit_reg)
                        begin
                            // target held scl too long: carry on regardless
                            seq_next.stretch_count = 17'd0;
                            seq_next.delay_count   =
                                i2cram_pkg::wait_len(i2cram_pkg::UNITS_1, unit);
                            seq_next.phase         = i2cram_pkg::PH_ACK_GIVEUP;
                        end
                        else
                        begin
                            seq_next.stretch_count = seq_reg.stretch_count + 17'd1;
                            seq_next.delay_count   =
                                i2cram_pkg::wait_len(i2cram_pkg::UNITS_1, unit);
                            seq_next.phase         = i2cram_pkg::PH_ACK_STRETCH;
                        end
                    end
                    i2cram_pkg::PH_ACK_GIVEUP:
                    begin
                        seq_next.delay_count = i2cram_pkg::wait_len(i2cram_pkg::UNITS_10, unit);
                        seq_next.phase       = i2cram_pkg::PH_ACK_HIGH;
                    end
                    i2cram_pkg::PH_ACK_HIGH:
                    begin
                        // sda high in the ack slot is a nack
                        if (data_pin_level)
                        begin
                            nack_next = 1'b1;
                        end
                        seq_next.clk_low     = 1'b1;
                        seq_next.delay_count = i2cram_pkg::wait_len(i2cram_pkg::UNITS_2, unit);
                        seq_next.phase       = i2cram_pkg::PH_ACK_TAIL;
                    end
                    i2cram_pkg::PH_ACK_TAIL:
                    begin
                        if (nack_reg)
                        begin
                            seq_next.clk_low     = 1'b1;
                            seq_next.dat_low     = 1'b1;
                            seq_next.delay_count =
                                i2cram_pkg::wait_len(i2cram_pkg::UNITS_4, unit);
                            seq_next.phase       = i2cram_pkg::PH_SP_LOW;
                        end
                        else
                        begin
                            seq_next.byte_step = seq_reg.byte_step + 3'd1;
                            seq_next = i2cram_pkg::enter_seg(seq_next, cmd_reg, unit);
                        end
                    end
                    i2cram_pkg::PH_RX_LOW:
                    begin
                        seq_next.clk_low     = 1'b0;
                        seq_next.delay_count = i2cram_pkg::wait_len(i2cram_pkg::UNITS_2, unit);
                        seq_next.phase       = i2cram_pkg::PH_RX_HIGH1;
                    end
                    i2cram_pkg::PH_RX_HIGH1:
                    begin
                        // sample sda mid clock-high
                        seq_next.shift_byte  = {seq_reg.shift_byte[6:0], data_pin_level};
                        seq_next.delay_count = i2cram_pkg::wait_len(i2cram_pkg::UNITS_2, unit);
                        seq_next.phase       = i2cram_pkg::PH_RX_HIGH2;
                    end
                    i2cram_pkg::PH_RX_HIGH2:
                    begin
                        seq_next.clk_low     = 1'b1;
                        seq_next.delay_count = i2cram_pkg::wait_len(i2cram_pkg::UNITS_4, unit);
                        seq_next.phase       = i2cram_pkg::PH_RX_TAIL;
                    end
                    i2cram_pkg::PH_RX_TAIL:
                    begin
                        if (seq_reg.bit_count == 3'd7)
                        begin
                            // master nack: leave sda released
                            seq_next.clk_low     = 1'b1;
                            seq_next.dat_low     = 1'b0;
                            seq_next.delay_count =
                                i2cram_pkg::wait_len(i2cram_pkg::UNITS_4, unit);
                            seq_next.phase       = i2cram_pkg::PH_NK_LOW;
                        end
                        else
                        begin
                            seq_next.bit_count   = seq_reg.bit_count + 3'd1;
                            seq_next.clk_low     = 1'b0;
                            seq_next.delay_count =
                                i2cram_pkg::wait_len(i2cram_pkg::UNITS_2, unit);
                            seq_next.phase       = i2cram_pkg::PH_RX_HIGH1;
                        end
                    end
                    i2cram_pkg::PH_NK_LOW:
                    begin
                        seq_next.clk_low     = 1'b0;
                        seq_next.delay_count = i2cram_pkg::wait_len(i2cram_pkg::UNITS_4, unit);
                        seq_next.phase       = i2cram_pkg::PH_NK_HIGH;
                    end
                    i2cram_pkg::PH_NK_HIGH:
                    begin
                        seq_next.clk_low     = 1'b1;
                        seq_next.delay_count = i2cram_pkg::wait_len(i2cram_pkg::UNITS_4, unit);
                        seq_next.phase       = i2cram_pkg::PH_NK_TAIL;
                    end
                    i2cram_pkg::PH_NK_TAIL:
                    begin
                        seq_next.byte_step = seq_reg.byte_step + 3'd1;
                        seq_next = i2cram_pkg::enter_seg(seq_next, cmd_reg, unit);
                    end
                    i2cram_pkg::PH_SP_LOW:
                    begin
                        seq_next.clk_low     = 1'b0;
                        seq_next.delay_count = i2cram_pkg::wait_len(i2cram_pkg::UNITS_4, unit);
                        seq_next.phase       = i2cram_pkg::PH_SP_HIGH;
                    end
                    i2cram_pkg::PH_SP_HIGH:
                    begin
                        // sda rises with scl high: stop, transaction over
                        seq_next.dat_low     = 1'b0;
                        seq_next.phase       = i2cram_pkg::PH_IDLE;
                        seq_next.delay_count = 12'd0;
                        if (!nack_reg && cmd_reg.is_read)
                        begin
                            rx_next = seq_reg.shift_byte;
                        end
                        done_c = 1'b1;
                        fail_c = nack_reg;
                    end
                    default:
                    begin
                        seq_next.phase       = i2cram_pkg::PH_IDLE;
                        seq_next.delay_count = 12'd0;
                        seq_next.clk_low     = 1'b0;
                        seq_next.dat_low     = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg  <= '0;
            cmd_reg  <= '0;
            nack_reg <= 1'b0;
            rx_reg   <= 8'd0;
        end
        else if (in_accept)
        begin
            seq_reg  <= seq_next;
            cmd_reg  <= cmd_next;
            nack_reg <= nack_next;
            rx_reg   <= rx_next;
        end
    end

    // result register handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            busy_reg       <= (seq_next.phase != i2cram_pkg::PH_IDLE);
            done_reg       <= done_c;
            failed_reg     <= done_c & fail_c;
            read_byte_reg  <= rx_next;
            active_bus_reg <= cmd_next.bus;
            clk_low_reg    <= seq_next.clk_low;
            dat_low_reg    <= seq_next.dat_low;
        end
    end

    assign out_valid       = out_valid_reg;
    assign busy_res        = busy_reg;
    assign done_res        = done_reg;
    assign failed          = failed_reg;
    assign read_byte       = read_byte_reg;
    assign active_bus      = active_bus_reg;
    assign clock_drive_low = clk_low_reg;
    assign data_drive_low  = dat_low_reg;

endmodule

[sim/i2c_register_access_master_unit_tb.sv]
`timescale 1ns / 100ps

module i2c_register_access_master_unit_tb;

    // word kinds on the input channel
    localparam logic ACT_COMMAND = 1'b0;
    localparam logic ACT_TICK    = 1'b1;

    // cycles without any accepted word before the run is declared hung;
    // the longest legal quiet stretch is the receiver hold
    localparam int STALL_LIMIT = 2000;

    // random phases: unit ticks, stretch limit, words that do something
    localparam int PHASES = 6;
    localparam int UNIT_PLAN [PHASES]  = '{0, 1, 2, 1, 3, 255};
    localparam int LIMIT_PLAN [PHASES] = '{0, 131071, 5, 1, 2, 65536};
    localparam int COUNT_PLAN [PHASES] = '{450, 350, 350, 250, 150, 100};

    // one input word as offered on the channel
    typedef struct packed {
        logic        action;
        logic        is_read;
        logic        wide;
        logic [6:0]  dev;
        logic [15:0] reg_addr;
        logic [7:0]  wbyte;
        logic [2:0]  bus;
        logic        scl;
        logic        sda;
    } word_t;

    // one result word
    typedef struct packed {
        logic       busy;
        logic       done;
        logic       fail;
        logic [7:0] rx_byte;
        logic [2:0] bus;
        logic       scl_low;
        logic       sda_low;
    } status_t;

    // tracks the bit sequencer of the master and the status words it owes
    class i2c_txn_tracker;
        logic [7:0]        unit_ticks;
        logic [16:0]       stretch_limit;
        logic [4:0]        phase;
        logic [2:0]        byte_step;
        logic [2:0]        bit_count;
        logic [7:0]        shift_byte;
        logic [11:0]       delay_count;
        logic [16:0]       stretch_count;
        i2cram_pkg::cmd_t  cmd;
        logic [7:0]        rx_byte;
        logic              scl_low;
        logic              sda_low;
        bit                nack;
        status_t           due_status[$];
        int                failures;

        function new();
            unit_ticks    = i2cram_pkg::UNIT_TICKS_RESET;
            stretch_limit = i2cram_pkg::STRETCH_LIMIT_RESET;
            phase         = i2cram_pkg::PH_IDLE;
            byte_step     = '0;
            bit_count     = '0;
            shift_byte    = '0;
            delay_count   = '0;
            stretch_count = '0;
            cmd           = '0;
            rx_byte       = '0;
            scl_low       = 1'b0;
            sda_low       = 1'b0;
            nack          = 1'b0;
            failures      = 0;
        endfunction

        function void write_reg(logic idx, logic [16:0] value);
            if (idx == i2cram_pkg::CFG_UNIT_TICKS)
                unit_ticks = value[7:0];
            else
                stretch_limit = value;
        endfunction

        // a unit count of zero behaves as one
        function void load_delay(int units, logic [4:0] next_phase);
            int per_unit;
            int span;
            per_unit    = (unit_ticks == 8'd0) ? 1 : int'(unit_ticks);
            span        = units * per_unit;
            delay_count = 12'(span);
            phase       = next_phase;
        endfunction

        // byte order: start, address, register byte(s), then data or a
        // repeated start, read address and the received byte; stop after that
        function logic [2:0] segment_kind();
            int base;
            int idx_step;
            idx_step = int'(byte_step);
            base     = cmd.wide ? 4 : 3;
            if (idx_step == 0)
                return i2cram_pkg::SEG_START;
            if (idx_step == 1)
                return i2cram_pkg::SEG_AW;
            if (cmd.wide && idx_step == 2)
                return i2cram_pkg::SEG_HI;
            if (idx_step == base - 1)
                return i2cram_pkg::SEG_LO;
            if (!cmd.is_read)
                return (idx_step == base) ? i2cram_pkg::SEG_DATA : i2cram_pkg::SEG_STOP;
            if (idx_step == base)
                return i2cram_pkg::SEG_START;
            if (idx_step == base + 1)
                return i2cram_pkg::SEG_AR;
            if (idx_step == base + 2)
                return i2cram_pkg::SEG_RECV;
            return i2cram_pkg::SEG_STOP;
        endfunction

        function void shift_out_bit();
            sda_low = ~shift_byte[3'd7 - bit_count];
            load_delay(2, i2cram_pkg::PH_TX_SETUP);
        endfunction

        function void begin_segment();
            logic [2:0] kind;
            kind = segment_kind();
            case (kind)
                i2cram_pkg::SEG_START:
                begin
                    scl_low = 1'b0;
                    sda_low = 1'b0;
                    load_delay(4, i2cram_pkg::PH_ST_A);
                end
                i2cram_pkg::SEG_RECV:
                begin
                    scl_low    = 1'b1;
                    sda_low    = 1'b0;
                    shift_byte = '0;
                    bit_count  = '0;
                    load_delay(4, i2cram_pkg::PH_RX_LOW);
                end
                i2cram_pkg::SEG_STOP:
                begin
                    scl_low = 1'b1;
                    sda_low = 1'b1;
                    load_delay(4, i2cram_pkg::PH_SP_LOW);
                end
                default:
                begin
                    case (kind)
                        i2cram_pkg::SEG_AW: shift_byte = {cmd.dev, 1'b0};
                        i2cram_pkg::SEG_AR: shift_byte = {cmd.dev, 1'b1};
                        i2cram_pkg::SEG_HI: shift_byte = cmd.regaddr[15:8];
                        i2cram_pkg::SEG_LO: shift_byte = cmd.regaddr[7:0];
                        default:            shift_byte = cmd.wbyte;
                    endcase
                    scl_low   = 1'b1;
                    bit_count = '0;
                    shift_out_bit();
                end
            endcase
        endfunction

        function void next_segment();
            byte_step = byte_step + 3'd1;
            begin_segment();
        endfunction

        // action at the last tick of a wait; returns 1 when the transfer ends
        function bit run_wait_end(logic scl, logic sda);
            case (phase)
                i2cram_pkg::PH_ST_A:
                begin
                    sda_low = 1'b1;
                    load_delay(4, i2cram_pkg::PH_ST_B);
                end
                i2cram_pkg::PH_ST_B:
                begin
                    scl_low = 1'b1;
                    next_segment();
                end
                i2cram_pkg::PH_TX_SETUP:
                begin
                    scl_low = 1'b0;
                    load_delay(4, i2cram_pkg::PH_TX_HIGH);
                end
                i2cram_pkg::PH_TX_HIGH:
                begin
                    scl_low = 1'b1;
                    load_delay(2, i2cram_pkg::PH_TX_HOLD);
                end
                i2cram_pkg::PH_TX_HOLD:
                begin
                    if (bit_count >= 3'd7)
                    begin
                        sda_low = 1'b0;
                        scl_low = 1'b1;
                        load_delay(10, i2cram_pkg::PH_ACK_LOW);
                    end
                    else
                    begin
                        bit_count = bit_count + 3'd1;
                        shift_out_bit();
                    end
                end
                i2cram_pkg::PH_ACK_LOW:
                begin
                    scl_low       = 1'b0;
                    stretch_count = '0;
                    delay_count   = 12'd1;
                    phase         = i2cram_pkg::PH_ACK_STRETCH;
                end
                i2cram_pkg::PH_ACK_STRETCH:
                begin
                    if (scl)
                        load_delay(10, i2cram_pkg::PH_ACK_HIGH);
                    else if (stretch_count >= stretch_limit)
                    begin
                        stretch_count = '0;
                        load_delay(1, i2cram_pkg::PH_ACK_GIVEUP);
                    end
                    else
                    begin
                        stretch_count = stretch_count + 17'd1;
                        load_delay(1, i2cram_pkg::PH_ACK_STRETCH);
                    end
                end
                i2cram_pkg::PH_ACK_GIVEUP:
                    load_delay(10, i2cram_pkg::PH_ACK_HIGH);
                i2cram_pkg::PH_ACK_HIGH:
                begin
                    if (sda)
                        nack = 1'b1;
                    scl_low = 1'b1;
                    load_delay(2, i2cram_pkg::PH_ACK_TAIL);
                end
                i2cram_pkg::PH_ACK_TAIL:
                begin
                    if (nack)
                    begin
                        scl_low = 1'b1;
                        sda_low = 1'b1;
                        load_delay(4, i2cram_pkg::PH_SP_LOW);
                    end
                    else
                        next_segment();
                end
                i2cram_pkg::PH_RX_LOW:
                begin
                    scl_low = 1'b0;
                    load_delay(2, i2cram_pkg::PH_RX_HIGH1);
                end
                i2cram_pkg::PH_RX_HIGH1:
                begin
                    shift_byte = {shift_byte[6:0], sda};
                    load_delay(2, i2cram_pkg::PH_RX_HIGH2);
                end
                i2cram_pkg::PH_RX_HIGH2:
                begin
                    scl_low = 1'b1;
                    load_delay(4, i2cram_pkg::PH_RX_TAIL);
                end
                i2cram_pkg::PH_RX_TAIL:
                begin
                    if (bit_count >= 3'd7)
                    begin
                        scl_low = 1'b1;
                        sda_low = 1'b0;
                        load_delay(4, i2cram_pkg::PH_NK_LOW);
                    end
                    else
                    begin
                        bit_count = bit_count + 3'd1;
                        scl_low   = 1'b0;
                        load_delay(2, i2cram_pkg::PH_RX_HIGH1);
                    end
                end
                i2cram_pkg::PH_NK_LOW:
                begin
                    scl_low = 1'b0;
                    load_delay(4, i2cram_pkg::PH_NK_HIGH);
                end
                i2cram_pkg::PH_NK_HIGH:
                begin
                    scl_low = 1'b1;
                    load_delay(4, i2cram_pkg::PH_NK_TAIL);
                end
                i2cram_pkg::PH_NK_TAIL:
                    next_segment();
                i2cram_pkg::PH_SP_LOW:
                begin
                    scl_low = 1'b0;
                    load_delay(4, i2cram_pkg::PH_SP_HIGH);
                end
                i2cram_pkg::PH_SP_HIGH:
                begin
                    sda_low     = 1'b0;
                    phase       = i2cram_pkg::PH_IDLE;
                    delay_count = '0;
                    if (!nack && cmd.is_read)
                        rx_byte = shift_byte;
                    return 1'b1;
                end
                default:
                begin
                    phase       = i2cram_pkg::PH_IDLE;
                    delay_count = '0;
                    scl_low     = 1'b0;
                    sda_low     = 1'b0;
                end
            endcase
            return 1'b0;
        endfunction

        // an accepted input word: advance the sequencer, queue the status it owes
        function void note_word(word_t w);
            status_t s;
            bit      ended;
            bit      bad_end;
            ended   = 1'b0;
            bad_end = 1'b0;
            if (w.action == ACT_COMMAND)
            begin
                // a command while a transfer runs is dropped
                if (phase == i2cram_pkg::PH_IDLE)
                begin
                    cmd.is_read = w.is_read;
                    cmd.wide    = w.wide;
                    cmd.dev     = w.dev;
                    cmd.regaddr = w.reg_addr;
                    cmd.wbyte   = w.wbyte;
                    cmd.bus     = w.bus;
                    nack        = 1'b0;
                    if (int'(cmd.bus) >= i2cram_pkg::BUS_COUNT)
                    begin
                        ended   = 1'b1;
                        bad_end = 1'b1;
                    end
                    else
                    begin
                        byte_step = '0;
                        begin_segment();
                    end
                end
            end
            else if (phase != i2cram_pkg::PH_IDLE)
            begin
                if (delay_count > 12'd1)
                    delay_count = delay_count - 12'd1;
                else if (run_wait_end(w.scl, w.sda))
                begin
                    ended   = 1'b1;
                    bad_end = nack;
                end
            end
            s.busy    = (phase != i2cram_pkg::PH_IDLE);
            s.done    = ended;
            s.fail    = ended && bad_end;
            s.rx_byte = rx_byte;
            s.bus     = cmd.bus;
            s.scl_low = scl_low;
            s.sda_low = sda_low;
            due_status.push_back(s);
        endfunction

        function string show(status_t s);
            return $sformatf({"busy %0b done %0b failed %0b byte %02h bus %0d",
                              " scl_low %0b sda_low %0b"},
                             s.busy, s.done, s.fail, s.rx_byte, s.bus, s.scl_low, s.sda_low);
        endfunction

        function void check_status(status_t got);
            status_t want;
            if (due_status.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("result with nothing due: %s", show(got));
                return;
            end
            want = due_status.pop_front();
            if (got.busy !== want.busy || got.done !== want.done || got.fail !== want.fail ||
                got.rx_byte !== want.rx_byte || got.bus !== want.bus ||
                got.scl_low !== want.scl_low || got.sda_low !== want.sda_low)
            begin
                failures++;
                if (failures <= 10)
                    $display("mismatch at %0t\n  expected %s\n  actual   %s",
                             $time, show(want), show(got));
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_write_en;
    logic        cfg_index;
    logic [16:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        action;
    logic        is_read;
    logic        wide_register_address;
    logic [6:0]  device_address;
    logic [15:0] register_address;
    logic [7:0]  write_byte;
    logic [2:0]  bus_number;
    logic        clock_pin_level;
    logic        data_pin_level;
    logic        out_valid;
    logic        out_stall;
    logic        busy_res;
    logic        done_res;
    logic        failed;
    logic [7:0]  read_byte;
    logic [2:0]  active_bus;
    logic        clock_drive_low;
    logic        data_drive_low;

    i2c_txn_tracker board;
    int             shape_count = 0;
    int             burst_left = 0;

    i2c_register_access_master_unit DUT
    (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cfg_write_en          (cfg_write_en),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data),
        .in_valid              (in_valid),
        .in_stall              (in_stall),
        .action                (action),
        .is_read               (is_read),
        .wide_register_address (wide_register_address),
        .device_address        (device_address),
        .register_address      (register_address),
        .write_byte            (write_byte),
        .bus_number            (bus_number),
        .clock_pin_level       (clock_pin_level),
        .data_pin_level        (data_pin_level),
        .out_valid             (out_valid),
        .out_stall             (out_stall),
        .busy_res              (busy_res),
        .done_res              (done_res),
        .failed                (failed),
        .read_byte             (read_byte),
        .active_bus            (active_bus),
        .clock_drive_low       (clock_drive_low),
        .data_drive_low        (data_drive_low)
    );

    // 100 MHz
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // pause length: mostly none or short, now and then long
    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic word_t make_cmd(logic rd, logic wide, logic [6:0] dev,
                                       logic [15:0] regaddr, logic [7:0] wbyte,
                                       logic [2:0] bus);
        word_t w;
        w.action   = ACT_COMMAND;
        w.is_read  = rd;
        w.wide     = wide;
        w.dev      = dev;
        w.reg_addr = regaddr;
        w.wbyte    = wbyte;
        w.bus      = bus;
        w.scl      = 1'($urandom_range(0, 1));
        w.sda      = 1'($urandom_range(0, 1));
        return w;
    endfunction

    function automatic word_t make_tick(logic scl, logic sda);
        word_t w;
        w     = make_cmd(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         7'($urandom_range(0, 127)), 16'($urandom_range(0, 65535)),
                         8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
        w.action = ACT_TICK;
        w.scl    = scl;
        w.sda    = sda;
        return w;
    endfunction

    // next random word, shaped by where the sequencer stands now; busy is set
    // when the word is one the block acts on (not a dropped command or an idle tick)
    function automatic word_t next_random_word(output bit busy);
        word_t w;
        int    r;
        r = $urandom_range(0, 99);
        if (board.phase == i2cram_pkg::PH_IDLE && r < 85)
        begin
            // transfer shapes rotate so every kind of transfer shows up
            w = make_cmd(shape_count[1], shape_count[0], 7'($urandom_range(0, 127)),
                         16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                         3'($urandom_range(0, 7)));
            shape_count++;
        end
        else if (board.phase != i2cram_pkg::PH_IDLE && r < 4)
            w = make_cmd(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         7'($urandom_range(0, 127)), 16'($urandom_range(0, 65535)),
                         8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
        else
        begin
            w = make_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            if (board.delay_count <= 12'd1)
            begin
                // target mostly releases the clock and mostly acknowledges,
                // so most transfers run to their end
                if (board.phase == i2cram_pkg::PH_ACK_STRETCH)
                    w.scl = ($urandom_range(0, 3) != 0);
                if (board.phase == i2cram_pkg::PH_ACK_HIGH)
                    w.sda = ($urandom_range(0, 15) == 0);
            end
        end
        busy = ((w.action == ACT_COMMAND) == (board.phase == i2cram_pkg::PH_IDLE));
        return w;
    endfunction

    // offer one word, hold it until taken, then maybe idle a while
    task automatic drive_word(input word_t w);
        int gap;
        action                <= w.action;
        is_read               <= w.is_read;
        wide_register_address <= w.wide;
        device_address        <= w.dev;
        register_address      <= w.reg_addr;
        write_byte            <= w.wbyte;
        bus_number            <= w.bus;
        clock_pin_level       <= w.scl;
        data_pin_level        <= w.sda;
        in_valid              <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        board.note_word(w);
        if (burst_left > 0)
        begin
            burst_left--;
            gap = 0;
        end
        else if ($urandom_range(0, 49) == 0)
        begin
            // back-to-back stretch
            burst_left = $urandom_range(20, 80);
            gap        = 0;
        end
        else
            gap = pick_pause();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop offering and wait until every owed status word has come back
    task automatic drain();
        in_valid <= 1'b0;
        while (board.due_status.size() != 0)
            @(posedge clk);
    endtask

    // both registers, back to back; spare upper data bits ride along on unit_ticks
    task automatic set_config(input logic [7:0] ut, input logic [16:0] sl);
        logic [16:0] ut_word;
        ut_word      = {9'($urandom_range(0, 511)), ut};
        cfg_write_en <= 1'b1;
        cfg_index    <= i2cram_pkg::CFG_UNIT_TICKS;
        cfg_data     <= ut_word;
        @(posedge clk);
        board.write_reg(i2cram_pkg::CFG_UNIT_TICKS, ut_word);
        cfg_index    <= i2cram_pkg::CFG_STRETCH_LIMIT;
        cfg_data     <= sl;
        @(posedge clk);
        board.write_reg(i2cram_pkg::CFG_STRETCH_LIMIT, sl);
        cfg_write_en <= 1'b0;
    endtask

    task automatic run_random(input int count);
        int    acted;
        bit    busy;
        word_t w;
        acted = 0;
        while (acted < count)
        begin
            w = next_random_word(busy);
            drive_word(w);
            if (busy)
                acted++;
        end
    endtask

    // stimulus
    initial
    begin
        board = new();
        rst_n                 <= 1'b0;
        cfg_write_en          <= 1'b0;
        cfg_index             <= i2cram_pkg::CFG_UNIT_TICKS;
        cfg_data              <= '0;
        in_valid              <= 1'b0;
        action                <= ACT_TICK;
        is_read               <= 1'b0;
        wide_register_address <= 1'b0;
        device_address        <= '0;
        register_address      <= '0;
        write_byte            <= '0;
        bus_number            <= '0;
        clock_pin_level       <= 1'b1;
        data_pin_level        <= 1'b1;
        out_stall             <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ticks while idle, every pin combination
        drive_word(make_tick(1'b0, 1'b0));
        drive_word(make_tick(1'b1, 1'b1));
        drive_word(make_tick(1'b0, 1'b1));
        drive_word(make_tick(1'b1, 1'b0));
        // wide read with every field at its top, then a command that is
        // dropped because the first one is still running
        drive_word(make_cmd(1'b1, 1'b1, 7'h7F, 16'hFFFF, 8'hFF, 3'd7));
        drive_word(make_cmd(1'b0, 1'b0, 7'h00, 16'h0000, 8'h00, 3'd0));
        // start condition and the first address bit
        for (int i = 0; i < 14; i++)
            drive_word(make_tick(i[0], i[1]));
        drain();

        // register writes land while a transfer is usually still in flight;
        // the first phase uses a unit count of zero
        for (int p = 0; p < PHASES; p++)
        begin
            set_config(8'(UNIT_PLAN[p]), 17'(LIMIT_PLAN[p]));
            run_random(COUNT_PLAN[p]);
            drain();
        end

        repeat (4) @(posedge clk);
        if (board.failures == 0 && board.due_status.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // result side: check every taken word, stall at random
    initial
    begin
        int      stall_left;
        int      quiet_left;
        int      results_seen;
        status_t got;
        stall_left   = 0;
        quiet_left   = 0;
        results_seen = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                got = {busy_res, done_res, failed, read_byte, active_bus,
                       clock_drive_low, data_drive_low};
                board.check_status(got);
                results_seen++;
                // long hold so the block backs up and stalls its input
                if (results_seen == 400 || results_seen == 1200)
                    stall_left = 250;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (quiet_left > 0)
            begin
                quiet_left--;
                out_stall <= 1'b0;
            end
            else if ($urandom_range(0, 49) == 0)
            begin
                // stretch with no stalls
                quiet_left = $urandom_range(20, 60);
                out_stall  <= 1'b0;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                stall_left = pick_pause();
                out_stall  <= (stall_left > 0);
                if (stall_left > 0)
                    stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // watchdog: too long with no word taken on either side
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (rst_n !== 1'b1 || (in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECK FAILED");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/i2cram_pkg.sv
hw/rtl/i2c_register_access_master_unit.sv
sim/i2c_register_access_master_unit_tb.sv
